// ===== rtl/oal_pkg.sv =====
// oal_pkg: shared types and constants for the ordered array list.
// Opcode and status codes, cell control struct, field widths.
// No dependencies.
package oal_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int OP_W  = 3;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_FIND       = 3'd6
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LOAD  = 2'd1,
        SEL_LEFT  = 2'd2,
        SEL_RIGHT = 2'd3
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t sel;
    } cell_ctrl_t;

endpackage

// ===== rtl/oal_cell.sv =====
// oal_cell: one list entry; loads, holds or takes a neighbor's word, and
// compares its word against the search key.
// Depends on oal_pkg.
module oal_cell
    import oal_pkg::*;
(
    input  logic                    aclk,
    input  cell_ctrl_t              ctrl,
    input  logic signed [VAL_W-1:0] load_data,
    input  logic signed [VAL_W-1:0] left_data,
    input  logic signed [VAL_W-1:0] right_data,
    input  logic signed [VAL_W-1:0] key,
    output logic signed [VAL_W-1:0] data,
    output logic                    match
);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    always_comb begin
        unique case (ctrl.sel)
            SEL_HOLD:  data_next = data_reg;
            SEL_LOAD:  data_next = load_data;
            SEL_LEFT:  data_next = left_data;
            SEL_RIGHT: data_next = right_data;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == key);

endmodule

// ===== rtl/ordered_array_list.sv =====
// ordered_array_list: ordered list of signed 32-bit words held in a row of
// shifting cells, with count, control and the result register.
// Depends on oal_pkg and oal_cell.
//
//   channel  direction  ports
//   s_       in         s_valid s_ready s_opcode s_position s_value
//   m_       out        m_valid m_ready m_status m_found_index m_item_count
//
// One transfer in, one result out. Every operation completes in the cycle of
// its input transfer: all cells shift or compare at once, find uses a priority
// encoder over the cell match bits. The registered result shows next cycle.
// s_ready is high while the result register is empty or being drained, so a
// new item is taken in the cycle its predecessor's result is taken.
// Reset empties the list and the result register; entries need no clearing.
module ordered_array_list
    import oal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_opcode,
    input  logic [POS_W-1:0]        s_position,
    input  logic signed [VAL_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ST_W-1:0]         m_status,
    output logic [IDX_W-1:0]        m_found_index,
    output logic [CNT_W-1:0]        m_item_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]           count_reg, count_next;
    logic                    m_valid_reg;
    status_t                 status_reg, status_next;
    logic [IDX_W-1:0]        found_reg, found_next;
    logic [CNT_W-1:0]        item_count_reg;

    logic                    accept;
    opcode_t                 op;
    logic [EW-1:0]           pos_ext, cnt_ext, at_pos;
    logic                    is_full, is_empty;
    logic                    do_ins, do_ers;

    cell_ctrl_t              ctrl [CAPACITY];
    logic signed [VAL_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]     match;
    logic                    found_any;
    logic [IW-1:0]           found_idx;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign op       = opcode_t'(s_opcode);
    assign pos_ext  = EW'(s_position);
    assign cnt_ext  = EW'(count_reg);
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb begin
        status_next = ST_DONE;
        found_next  = '0;
        count_next  = count_reg;
        do_ins      = 1'b0;
        do_ers      = 1'b0;
        at_pos      = '0;
        unique case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                at_pos = (op == OP_PUSH_BACK) ? cnt_ext : '0;
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_INSERT: begin
                at_pos = pos_ext;
                if (pos_ext > cnt_ext) begin
                    status_next = ST_RANGE;
                end else if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    status_next = ST_RANGE;
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            OP_POP_FRONT, OP_ERASE: begin
                at_pos = (op == OP_ERASE) ? pos_ext : '0;
                if (at_pos >= cnt_ext) begin
                    status_next = ST_RANGE;
                end else begin
                    do_ers     = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_FIND: begin
                if (found_any) begin
                    found_next = IDX_W'(found_idx);
                end else begin
                    status_next = ST_NOTFOUND;
                end
            end
            default: begin
                status_next = ST_RANGE;
            end
        endcase
    end

    always_comb begin
        found_any = 1'b0;
        found_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match[i]) begin
                found_any = 1'b1;
                found_idx = IW'(i);
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] left_w, right_w;
        logic                    hit;

        if (g == 0) begin : g_first
            assign left_w = s_value;
        end else begin : g_mid_l
            assign left_w = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_w = cell_data[g];
        end else begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        always_comb begin
            ctrl[g].sel = SEL_HOLD;
            if (accept && do_ins) begin
                if (EW'(g) == at_pos) begin
                    ctrl[g].sel = SEL_LOAD;
                end else if (EW'(g) > at_pos) begin
                    ctrl[g].sel = SEL_LEFT;
                end
            end else if (accept && do_ers && (EW'(g) >= at_pos)) begin
                ctrl[g].sel = SEL_RIGHT;
            end
        end

        oal_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl[g]),
            .load_data  (s_value),
            .left_data  (left_w),
            .right_data (right_w),
            .key        (s_value),
            .data       (cell_data[g]),
            .match      (hit)
        );

        assign match[g] = hit && (EW'(g) < cnt_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg     <= status_next;
            found_reg      <= found_next;
            item_count_reg <= CNT_W'(count_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_found_index = found_reg;
    assign m_item_count  = item_count_reg;

endmodule

// ===== bench/oal_list_sb_pkg.sv =====
// oal_list_sb_pkg: scoreboard for the ordered array list bench.
// Keeps a shadow list, predicts one result per input transfer and checks results in order.
// Depends on oal_pkg.
package oal_list_sb_pkg;
    import oal_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  count;
    } list_result_t;

    class list_scoreboard;
        logic [VAL_W-1:0] cells [CAPACITY_DEF];
        int unsigned      fill;
        list_result_t     pending [$];
        int unsigned      errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10) begin
                $display("%0t ns: %s", $time, what);
            end
        endfunction

        function void note_transfer(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                    logic [VAL_W-1:0] val);
            list_result_t r;
            int unsigned  at;
            at       = 32'(pos);
            r.status = ST_DONE;
            r.index  = '0;
            case (op)
                OP_PUSH_BACK: begin
                    if (fill >= CAPACITY_DEF) r.status = ST_FULL;
                    else begin
                        cells[fill] = val;
                        fill++;
                    end
                end
                OP_POP_BACK: begin
                    if (fill == 0) r.status = ST_RANGE;
                    else fill--;
                end
                OP_PUSH_FRONT: begin
                    if (fill >= CAPACITY_DEF) r.status = ST_FULL;
                    else begin
                        for (int i = fill; i > 0; i--) cells[i] = cells[i-1];
                        cells[0] = val;
                        fill++;
                    end
                end
                OP_POP_FRONT: begin
                    if (fill == 0) r.status = ST_RANGE;
                    else begin
                        for (int i = 0; i + 1 < fill; i++) cells[i] = cells[i+1];
                        fill--;
                    end
                end
                OP_INSERT: begin
                    if (at > fill) r.status = ST_RANGE;
                    else if (fill >= CAPACITY_DEF) r.status = ST_FULL;
                    else begin
                        for (int i = fill; i > at; i--) cells[i] = cells[i-1];
                        cells[at] = val;
                        fill++;
                    end
                end
                OP_ERASE: begin
                    if (at >= fill) r.status = ST_RANGE;
                    else begin
                        for (int i = at; i + 1 < fill; i++) cells[i] = cells[i+1];
                        fill--;
                    end
                end
                OP_FIND: begin
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < fill; i++) begin
                        if (cells[i] == val) begin
                            r.status = ST_DONE;
                            r.index  = i[IDX_W-1:0];
                            break;
                        end
                    end
                end
                default: r.status = ST_RANGE;
            endcase
            r.count = fill[CNT_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [ST_W-1:0] st, logic [IDX_W-1:0] idx,
                                   logic [CNT_W-1:0] cnt);
            list_result_t want;
            if (pending.size() == 0) begin
                flag($sformatf("result with no transfer pending: status %0d index %0d count %0d",
                               st, idx, cnt));
                return;
            end
            want = pending.pop_front();
            if (want.status !== st || want.index !== idx || want.count !== cnt) begin
                flag($sformatf("result error: expected status %0d index %0d count %0d, got %0d %0d %0d",
                               want.status, want.index, want.count, st, idx, cnt));
            end
        endfunction

        function void check_drained();
            if (pending.size() != 0) begin
                flag($sformatf("%0d results never arrived", pending.size()));
            end
        endfunction
    endclass

endpackage

// ===== bench/tb_top.sv =====
// tb_top: bench for ordered_array_list, directed list operations then random phases
// with varying sender gaps, receiver stalls and one long receiver hold-off.
// Depends on oal_pkg, oal_list_sb_pkg and the ordered_array_list RTL.
module tb_top
    import oal_pkg::*;
    import oal_list_sb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int               LIMIT     = 200000;
    localparam int               HOLD_LEN  = 400;
    localparam logic [OP_W-1:0]  OP_UNUSED = 3'd7;

    logic                    aclk       = 1'b0;
    logic                    aresetn    = 1'b0;
    logic                    s_valid    = 1'b0;
    logic [OP_W-1:0]         s_opcode   = '0;
    logic [POS_W-1:0]        s_position = '0;
    logic signed [VAL_W-1:0] s_value    = '0;
    logic                    m_ready    = 1'b0;
    logic                    s_ready;
    logic                    m_valid;
    logic [ST_W-1:0]         m_status;
    logic [IDX_W-1:0]        m_found_index;
    logic [CNT_W-1:0]        m_item_count;

    int unsigned    send_idle_pct  = 0;
    int unsigned    recv_stall_pct = 0;
    bit             hold_req       = 1'b0;
    bit             hold_done      = 1'b0;
    int             hold_left      = 0;
    int unsigned    cycles         = 0;
    list_scoreboard sb;

    ordered_array_list u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_index (m_found_index),
        .m_item_count  (m_item_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("ordered_array_list: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off when requested
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_status, m_found_index, m_item_count);
            if (s_valid && s_ready) sb.note_transfer(s_opcode, s_position, s_value);
        end
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_position <= pos;
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_directed();
        send_item(OP_POP_BACK, 0, 0);
        send_item(OP_POP_FRONT, 0, 0);
        send_item(OP_ERASE, 0, 0);
        send_item(OP_FIND, 0, 5);
        send_item(OP_UNUSED, 31, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 1, 7);
        send_item(OP_INSERT, 0, 32'h7FFF_FFFF);
        send_item(OP_PUSH_FRONT, 0, 32'h8000_0000);
        send_item(OP_PUSH_BACK, 0, 0);
        send_item(OP_INSERT, 3, 32'hFFFF_FFFF);
        send_item(OP_FIND, 0, 0);
        send_item(OP_FIND, 0, 32'h8000_0000);
        for (int i = 0; i < 12; i++) begin
            send_item((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, 0, i);
        end
        send_item(OP_PUSH_BACK, 0, 1);
        send_item(OP_PUSH_FRONT, 0, 2);
        send_item(OP_INSERT, 17, 3);
        send_item(OP_INSERT, 16, 4);
        send_item(OP_ERASE, 16, 0);
        send_item(OP_FIND, 0, 32'hFFFF_FFFF);
        send_item(OP_POP_FRONT, 0, 0);
        send_item(OP_POP_BACK, 0, 0);
        send_item(OP_ERASE, 7, 0);
    endtask

    // grow- and shrink-biased segments are picked at random so the list swings between empty and full
    task automatic run_random(int items);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int               grow_pct;
        int               w;
        grow_pct = 50;
        for (int n = 0; n < items; n++) begin
            if (n % 40 == 0) grow_pct = $urandom_range(1) ? 50 : 20;
            w = $urandom_range(99);
            if (w < 3) op = OP_UNUSED;
            else if (w < 3 + grow_pct) begin
                case ($urandom_range(2))
                    0:       op = OP_PUSH_BACK;
                    1:       op = OP_PUSH_FRONT;
                    default: op = OP_INSERT;
                endcase
            end else if (w < 83) begin
                case ($urandom_range(2))
                    0:       op = OP_POP_BACK;
                    1:       op = OP_POP_FRONT;
                    default: op = OP_ERASE;
                endcase
            end else op = OP_FIND;
            pos = POS_W'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(16));
            case ($urandom_range(3))
                0, 1: val = $urandom_range(8) - 4;
                2: begin
                    case ($urandom_range(3))
                        0:       val = 32'h7FFF_FFFF;
                        1:       val = 32'h8000_0000;
                        2:       val = 32'h0000_0000;
                        default: val = 32'hFFFF_FFFF;
                    endcase
                end
                default: val = $urandom;
            endcase
            send_item(op, pos, val);
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();

        hold_req <= 1'b1;
        run_random(450);
        send_idle_pct = 50;
        run_random(450);
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        run_random(450);
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        run_random(450);
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("ordered_array_list: match");
        end else begin
            $display("ordered_array_list: mismatch");
        end
        $finish;
    end

endmodule
